// ----- rtl/core/slr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

    // Field widths of the command and result ports.
    localparam int IN_SET_W  = 11;
    localparam int IN_WAY_W  = 4;
    localparam int ADDR_W    = 64;
    localparam int MASK_W    = 16;
    localparam int OUT_WAY_W = 4;
    localparam int KIND_W    = 2;

    // Per-way age counter and its saturation value.
    localparam int           AGE_W   = 8;
    localparam logic [7:0]   AGE_MAX = 8'd255;

    // The signature starts at address bit 6 (one 64-byte line).
    localparam int SIG_SHIFT = 6;

    // Locality score in unsigned Q1.16.
    localparam int          SCORE_W    = 17;
    localparam int          SCORE_FRAC = 16;
    localparam logic [16:0] SCORE_ONE  = 17'd65536;
    localparam logic [16:0] SCORE_HALF = 17'd32768;

    // Default configuration of the replacement store.
    localparam int DEF_NUM_SETS      = 2048;
    localparam int DEF_NUM_WAYS      = 16;
    localparam int DEF_SIG_BITS      = 12;
    localparam int DEF_HISTORY_DEPTH = 8;
    localparam int DEF_REUSE_MAX     = 15;

    // Command codes.
    localparam logic ACT_QUERY  = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_INVALID  = 2'd0,
        KIND_MISMATCH = 2'd1,
        KIND_ALL      = 2'd2,
        KIND_UPDATE   = 2'd3
    } t_kind;

    // Controller states.
    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_READ  = 2'd2,
        S_SCORE = 2'd3
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/signature_locality_replacement_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Payload
// command   in         start, busy          i_action, i_set_index, i_way, i_address,
//                                           i_line_valid_mask, i_hit
// result    out        o_valid (strobe)     o_victim_way, o_victim_kind
//
// A command transfers at a rising edge with start high and busy low; the set word is read
// from the set memory at that edge. An update, or a query that finds a clear mask bit,
// strobes its result from the read state; a query that scores the set strobes from the
// scoring state, which follows the read state. Busy stays high through both states, so a
// new command is taken only once the last one is finished and its result registered.
// After reset a clearing pass writes zero into every set, with busy high.
// The result is shown for one cycle and cannot be held off by the receiver.

module signature_locality_replacement_top #(
    parameter int NUM_SETS      = slr_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS      = slr_pkg::DEF_NUM_WAYS,
    parameter int SIG_BITS      = slr_pkg::DEF_SIG_BITS,
    parameter int HISTORY_DEPTH = slr_pkg::DEF_HISTORY_DEPTH,
    parameter int REUSE_MAX     = slr_pkg::DEF_REUSE_MAX
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_action,
    input  wire logic [slr_pkg::IN_SET_W-1:0]  i_set_index,
    input  wire logic [slr_pkg::IN_WAY_W-1:0]  i_way,
    input  wire logic [slr_pkg::ADDR_W-1:0]    i_address,
    input  wire logic [slr_pkg::MASK_W-1:0]    i_line_valid_mask,
    input  wire logic                          i_hit,
    output logic                               o_valid,
    output logic [slr_pkg::OUT_WAY_W-1:0]      o_victim_way,
    output logic [slr_pkg::KIND_W-1:0]         o_victim_kind
);

    // Derived widths.
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int NPOW      = 1 << WAY_W;
    localparam int PTR_W     = $clog2(HISTORY_DEPTH);
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int REUSE_W   = $clog2(REUSE_MAX + 1);
    localparam int KEY_W     = 1 + REUSE_W + slr_pkg::AGE_W;
    localparam int MASK_WAYS = (NUM_WAYS < slr_pkg::MASK_W) ? NUM_WAYS : slr_pkg::MASK_W;

    // Score update: floor(num / DIV) with num = 4*H*score + 65536*matches, done as an exact
    // multiply by a rounded-up reciprocal over the full range of num.
    localparam int              DIV    = 5 * HISTORY_DEPTH;
    localparam int              NUM_W  = $clog2(DIV * 65536 + 1);
    localparam int              DIV_L  = $clog2(DIV);
    localparam int              SH     = NUM_W + DIV_L;
    localparam longint unsigned RECIP  = ((64'd1 << SH) + DIV - 1) / DIV;
    localparam int              RECIP_W = NUM_W + 1;
    localparam int              PROD_W  = NUM_W + RECIP_W;

    // One set word of the memory.
    typedef struct packed {
        logic                           valid;
        logic [slr_pkg::AGE_W-1:0]      age;
        logic [REUSE_W-1:0]             reuse;
        logic [SIG_BITS-1:0]            sig;
    } t_way_meta;

    typedef struct packed {
        logic [HISTORY_DEPTH-1:0][SIG_BITS-1:0] hist;
        logic [PTR_W-1:0]                       ptr;
        logic [slr_pkg::SCORE_W-1:0]            score;
        t_way_meta [NUM_WAYS-1:0]               ways;
    } t_set_entry;

    // Set memory.
    t_set_entry r_set_mem [NUM_SETS];

    // Control state.
    slr_pkg::t_state r_state, n_state;
    logic [SET_W-1:0] r_clr_addr;
    logic             r_out_valid, n_out_valid;

    // Captured command.
    logic                         r_action;
    logic [SET_W-1:0]             r_set;
    logic [slr_pkg::IN_WAY_W-1:0] r_way;
    logic [SIG_BITS-1:0]          r_sig;
    logic [slr_pkg::MASK_W-1:0]   r_mask;
    logic                         r_hit;

    // Read data and intermediate results.
    t_set_entry                     r_rdata;
    logic [NUM_W-1:0]               r_num, n_num;
    logic [WAY_W-1:0]               r_pick_mis, r_pick_all;
    logic                           r_mis_ok;
    logic [slr_pkg::OUT_WAY_W-1:0]  r_out_way, n_out_way;
    slr_pkg::t_kind                 r_out_kind, n_out_kind;

    // Datapath and memory port signals.
    logic                         accept;
    logic [SET_W-1:0]             set_mod;
    logic                         mem_we;
    logic [SET_W-1:0]             wr_addr;
    t_set_entry                   wr_data;
    t_set_entry                   upd_entry;
    t_set_entry                   score_entry;
    logic                         inv_found;
    logic [slr_pkg::OUT_WAY_W-1:0] inv_way;
    logic [CNT_W-1:0]             match_cnt;
    logic [WAY_W:0]               mis_res, all_res;
    logic [NPOW-1:0][KEY_W-1:0]   mis_keys, all_keys;
    logic [PROD_W-1:0]            prod;
    logic [slr_pkg::SCORE_W-1:0]  score_next;
    logic                         score_high;
    logic                         way_in_range;
    logic [WAY_W-1:0]             way_sel;

    // Minimum search as a tree of pairwise compares; ties keep the lower way.
    // The top bit of the returned word is set when the winner was excluded.
    function automatic logic [WAY_W:0] pick_min(input logic [NPOW-1:0][KEY_W-1:0] keys);
        logic [NPOW-1:0][KEY_W-1:0] k;
        logic [NPOW-1:0][WAY_W-1:0] idx;
        k = keys;
        for (int i = 0; i < NPOW; i++) begin
            idx[i] = WAY_W'(i);
        end
        for (int step = 1; step < NPOW; step = step * 2) begin
            for (int i = 0; i < NPOW; i = i + 2 * step) begin
                if (k[i + step] < k[i]) begin
                    k[i]   = k[i + step];
                    idx[i] = idx[i + step];
                end
            end
        end
        return {k[0][KEY_W-1], idx[0]};
    endfunction

    assign busy   = (r_state != slr_pkg::S_IDLE);
    assign accept = start && !busy;

    // Reduce the set index modulo NUM_SETS by conditional subtraction of shifted multiples.
    always_comb begin
        logic [31:0] x;
        x = 32'(i_set_index);
        for (int k = slr_pkg::IN_SET_W - 1; k >= 0; k--) begin
            if ((longint'(NUM_SETS) << k) < (longint'(1) << slr_pkg::IN_SET_W)) begin
                if (x >= (32'(NUM_SETS) << k)) begin
                    x = x - (32'(NUM_SETS) << k);
                end
            end
        end
        set_mod = SET_W'(x);
    end

    // Lowest way that is clear in the valid mask.
    always_comb begin
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = MASK_WAYS - 1; w >= 0; w--) begin
            if (!r_mask[w]) begin
                inv_found = 1'b1;
                inv_way   = slr_pkg::OUT_WAY_W'(w);
            end
        end
    end

    // History matches and the numerator of the new score.
    always_comb begin
        match_cnt = '0;
        for (int h = 0; h < HISTORY_DEPTH; h++) begin
            match_cnt = match_cnt + CNT_W'(r_rdata.hist[h] == r_sig);
        end
        n_num = NUM_W'(r_rdata.score) * NUM_W'(4 * HISTORY_DEPTH)
              + (NUM_W'(match_cnt) << slr_pkg::SCORE_FRAC);
    end

    // Victim keys: lower reuse first, then greater age; mismatch keys rank a matching signature last.
    always_comb begin
        for (int w = 0; w < NPOW; w++) begin
            if (w < NUM_WAYS) begin
                mis_keys[w] = {r_rdata.ways[w].sig == r_sig, r_rdata.ways[w].reuse,
                               ~r_rdata.ways[w].age};
                all_keys[w] = {1'b0, r_rdata.ways[w].reuse, ~r_rdata.ways[w].age};
            end else begin
                mis_keys[w] = '1;
                all_keys[w] = '1;
            end
        end
        mis_res = pick_min(mis_keys);
        all_res = pick_min(all_keys);
    end

    // New score from the registered numerator.
    assign prod       = PROD_W'(r_num) * PROD_W'(RECIP);
    assign score_next = slr_pkg::SCORE_W'(prod >> SH);
    assign score_high = (score_next > slr_pkg::SCORE_HALF);

    always_comb begin
        score_entry       = r_rdata;
        score_entry.score = score_next;
    end

    // Access update of the set word.
    assign way_in_range = (32'(r_way) < NUM_WAYS);
    assign way_sel      = WAY_W'(r_way);

    always_comb begin
        upd_entry = r_rdata;
        upd_entry.hist[r_rdata.ptr] = r_sig;
        upd_entry.ptr = (r_rdata.ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_rdata.ptr + 1'b1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (r_rdata.ways[w].valid && (r_rdata.ways[w].age != slr_pkg::AGE_MAX)) begin
                upd_entry.ways[w].age = r_rdata.ways[w].age + 1'b1;
            end
        end
        if (way_in_range) begin
            upd_entry.ways[way_sel].age = '0;
            upd_entry.ways[way_sel].sig = r_sig;
            if (r_hit) begin
                if (r_rdata.ways[way_sel].reuse != REUSE_W'(REUSE_MAX)) begin
                    upd_entry.ways[way_sel].reuse = r_rdata.ways[way_sel].reuse + 1'b1;
                end
            end else begin
                upd_entry.ways[way_sel].valid = 1'b1;
                upd_entry.ways[way_sel].reuse = REUSE_W'(1);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            slr_pkg::S_CLEAR: begin
                if (r_clr_addr == SET_W'(NUM_SETS - 1)) begin
                    n_state = slr_pkg::S_IDLE;
                end
            end
            slr_pkg::S_IDLE: begin
                if (start) begin
                    n_state = slr_pkg::S_READ;
                end
            end
            slr_pkg::S_READ: begin
                if ((r_action == slr_pkg::ACT_UPDATE) || inv_found) begin
                    n_state = slr_pkg::S_IDLE;
                end else begin
                    n_state = slr_pkg::S_SCORE;
                end
            end
            slr_pkg::S_SCORE: begin
                n_state = slr_pkg::S_IDLE;
            end
            default: begin
                n_state = slr_pkg::S_CLEAR;
            end
        endcase
    end

    // Memory write and result outputs per state.
    always_comb begin
        mem_we      = 1'b0;
        wr_addr     = r_set;
        wr_data     = upd_entry;
        n_out_valid = 1'b0;
        n_out_way   = '0;
        n_out_kind  = slr_pkg::KIND_UPDATE;
        case (r_state)
            slr_pkg::S_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
            end
            slr_pkg::S_IDLE: begin
                mem_we = 1'b0;
            end
            slr_pkg::S_READ: begin
                if (r_action == slr_pkg::ACT_UPDATE) begin
                    mem_we      = 1'b1;
                    n_out_valid = 1'b1;
                end else if (inv_found) begin
                    n_out_valid = 1'b1;
                    n_out_way   = inv_way;
                    n_out_kind  = slr_pkg::KIND_INVALID;
                end
            end
            slr_pkg::S_SCORE: begin
                mem_we      = 1'b1;
                wr_data     = score_entry;
                n_out_valid = 1'b1;
                if (score_high && r_mis_ok) begin
                    n_out_way  = slr_pkg::OUT_WAY_W'(r_pick_mis);
                    n_out_kind = slr_pkg::KIND_MISMATCH;
                end else begin
                    n_out_way  = slr_pkg::OUT_WAY_W'(r_pick_all);
                    n_out_kind = slr_pkg::KIND_ALL;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slr_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == slr_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Command capture on transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_set    <= set_mod;
            r_way    <= i_way;
            r_sig    <= i_address[slr_pkg::SIG_SHIFT +: SIG_BITS];
            r_mask   <= i_line_valid_mask;
            r_hit    <= i_hit;
        end
    end

    // Intermediate and result payload registers.
    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_pick_mis <= mis_res[WAY_W-1:0];
        r_mis_ok   <= !mis_res[WAY_W];
        r_pick_all <= all_res[WAY_W-1:0];
        r_out_way  <= n_out_way;
        r_out_kind <= n_out_kind;
    end

    // Set memory: one read port registered, one write port.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= r_set_mem[set_mod];
        end
        if (mem_we) begin
            r_set_mem[wr_addr] <= wr_data;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_victim_way  = r_out_way;
    assign o_victim_kind = r_out_kind;

    // A result strobe follows only a read or a scoring cycle.
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == slr_pkg::S_READ || $past(r_state) == slr_pkg::S_SCORE))
        else $error("result strobe without a finishing cycle");

    // A transfer always moves the controller to the read cycle.
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == slr_pkg::S_READ))
        else $error("command transfer did not start a set read");

    // The set memory is never written while idle.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slr_pkg::S_IDLE) |-> !mem_we)
        else $error("set memory written while idle");

    // A rescored set never holds a score above one.
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slr_pkg::S_SCORE) |-> (score_next <= slr_pkg::SCORE_ONE))
        else $error("locality score out of range");

endmodule

`default_nettype wire
